/* src/z_ordered_rectangle_hit_table_core_macros.svh */
// Assertion macros for the z-ordered rectangle hit table.
// Included by the checker; depends on nothing else.
`ifndef Z_ORDERED_RECTANGLE_HIT_TABLE_CORE_MACROS_SVH
`define Z_ORDERED_RECTANGLE_HIT_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZORHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zorht: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ZORHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zorht: next-cycle assertion failed");

`endif

/* src/zorht_pkg.sv */
// Shared types and constants of the z-ordered rectangle hit table.
// Used by the core and by its checker; depends on nothing.
package zorht_pkg;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SET_RECT = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_t;

  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int RECT_DIM_W  = 15;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;

endpackage

/* src/zorht_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; instantiated by the hit table core.
module zorht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/z_ordered_rectangle_hit_table_core.sv */
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid / in_tready  tuser: operation; tdata: slot, rectangle, point
// out_     out  out_tvalid / out_tready tuser: status, hit; tdata: result_slot, region_count
//
// Query, insert and remove make one pass over the rank and rectangle memories at one
// entry per cycle; set rectangle and any rejected item skip that pass.
// Reset is synchronous and active low and needs no clearing pass.
// A waiting result sits in the output register while the next item is accepted.
// Depends on zorht_pkg and zorht_ram.
module z_ordered_rectangle_hit_table_core #(
  parameter int MAX_REGIONS = 16,
  parameter int COORD_BITS  = 16,
  localparam int IN_BITS    = 4 + 2 * zorht_pkg::RECT_DIM_W + 4 * COORD_BITS,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: slot, rect_left, rect_top, rect_width, rect_height,
  // point_x, point_y, zero fill.
  input  logic [IN_TDATA_W-1:0]               in_tdata,
  // Fields from bit 0: operation.
  input  logic [zorht_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: result_slot, region_count, zero fill.
  output logic [zorht_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Fields from bit 0: status, hit.
  output logic [zorht_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int DIM_W = zorht_pkg::RECT_DIM_W;
  localparam int REC_W = 2 * COORD_BITS + 2 * DIM_W;
  localparam int DW    = ((COORD_BITS + 1 > DIM_W + 1) ? COORD_BITS + 1 : DIM_W + 1) + 1;
  localparam int OFS_LEFT = zorht_pkg::SLOT_W;
  localparam int OFS_TOP  = OFS_LEFT + COORD_BITS;
  localparam int OFS_W    = OFS_TOP + COORD_BITS;
  localparam int OFS_H    = OFS_W + DIM_W;
  localparam int OFS_X    = OFS_H + DIM_W;
  localparam int OFS_Y    = OFS_X + COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REM_RANK,
    S_SWEEP,
    S_TAIL,
    S_INS_WR,
    S_FINISH
  } state_t;

  state_t                          state_r, state_nxt;
  zorht_pkg::op_t                  op_r, op_nxt;
  logic [zorht_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic signed [COORD_BITS-1:0]    left_r, left_nxt, top_r, top_nxt;
  logic [DIM_W-1:0]                wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic signed [COORD_BITS-1:0]    px_r, px_nxt, py_r, py_nxt;
  logic [MAX_REGIONS-1:0]          in_use_r, in_use_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [IDX_W-1:0]                rd_idx_r, rd_idx_nxt;
  logic                            p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]                p_idx_r, p_idx_nxt;
  logic [IDX_W-1:0]                gone_r, gone_nxt;
  logic                            free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]                free_idx_r, free_idx_nxt;
  logic                            hit_r, hit_nxt;
  logic [IDX_W-1:0]                best_r, best_nxt;
  logic [IDX_W-1:0]                best_slot_r, best_slot_nxt;
  zorht_pkg::status_t              res_status_r, res_status_nxt;
  logic                            out_vld_r, out_vld_nxt;
  zorht_pkg::status_t              out_status_r, out_status_nxt;
  logic                            out_hit_r, out_hit_nxt;
  logic [IDX_W-1:0]                out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]                out_count_r, out_count_nxt;

  logic                            rank_we, rect_we;
  logic [IDX_W-1:0]                rank_waddr, rank_raddr, rect_waddr;
  logic [IDX_W-1:0]                rank_wdata, rank_rdata;
  logic [REC_W-1:0]                rect_wdata, rect_rdata;

  logic [IDX_W-1:0]                slot_idx;
  logic                            slot_ok;
  logic signed [COORD_BITS-1:0]    r_left, r_top;
  logic [DIM_W-1:0]                r_wid, r_hgt;
  logic signed [DW-1:0]            dx, dy, wx, hy;
  logic                            holds, p_used;

  zorht_ram #(.WIDTH(IDX_W), .DEPTH(MAX_REGIONS)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  zorht_ram #(.WIDTH(REC_W), .DEPTH(MAX_REGIONS)) u_rect_ram (
    .clk   (clk),
    .we    (rect_we),
    .waddr (rect_waddr),
    .wdata (rect_wdata),
    .raddr (rd_idx_r),
    .rdata (rect_rdata)
  );

  assign slot_idx = IDX_W'(slot_r);
  assign slot_ok  = (32'(slot_r) < MAX_REGIONS) && in_use_r[slot_idx];

  assign r_left = rect_rdata[COORD_BITS-1:0];
  assign r_top  = rect_rdata[2*COORD_BITS-1:COORD_BITS];
  assign r_wid  = rect_rdata[2*COORD_BITS+DIM_W-1:2*COORD_BITS];
  assign r_hgt  = rect_rdata[REC_W-1:2*COORD_BITS+DIM_W];

  assign dx     = DW'(px_r) - DW'(r_left);
  assign dy     = DW'(py_r) - DW'(r_top);
  assign wx     = $signed(DW'(r_wid));
  assign hy     = $signed(DW'(r_hgt));
  assign holds  = !dx[DW-1] && (dx < wx) && !dy[DW-1] && (dy < hy);
  assign p_used = in_use_r[p_idx_r];

  assign rect_wdata = {hgt_r, wid_r, top_r, left_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    left_nxt       = left_r;
    top_nxt        = top_r;
    wid_nxt        = wid_r;
    hgt_nxt        = hgt_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    in_use_nxt     = in_use_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = p_idx_r;
    gone_nxt       = gone_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    hit_nxt        = hit_r;
    best_nxt       = best_r;
    best_slot_nxt  = best_slot_r;
    res_status_nxt = res_status_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    rank_we        = 1'b0;
    rank_waddr     = p_idx_r;
    rank_wdata     = rank_rdata;
    rank_raddr     = rd_idx_r;
    rect_we        = 1'b0;
    rect_waddr     = slot_idx;

    if (p_vld_r) begin
      case (op_r)
        zorht_pkg::OP_INSERT: begin
          if (p_used) begin
            rank_we    = 1'b1;
            rank_wdata = rank_rdata + IDX_W'(1);
          end else if (!free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = p_idx_r;
          end
        end
        zorht_pkg::OP_REMOVE: begin
          if (p_used && (rank_rdata > gone_r)) begin
            rank_we    = 1'b1;
            rank_wdata = rank_rdata - IDX_W'(1);
          end
        end
        zorht_pkg::OP_QUERY: begin
          if (p_used && holds && (!hit_r || (rank_rdata < best_r))) begin
            hit_nxt       = 1'b1;
            best_nxt      = rank_rdata;
            best_slot_nxt = p_idx_r;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = zorht_pkg::op_t'(in_tuser[1:0]);
          slot_nxt  = in_tdata[zorht_pkg::SLOT_W-1:0];
          left_nxt  = in_tdata[OFS_LEFT +: COORD_BITS];
          top_nxt   = in_tdata[OFS_TOP +: COORD_BITS];
          wid_nxt   = in_tdata[OFS_W +: DIM_W];
          hgt_nxt   = in_tdata[OFS_H +: DIM_W];
          px_nxt    = in_tdata[OFS_X +: COORD_BITS];
          py_nxt    = in_tdata[OFS_Y +: COORD_BITS];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        hit_nxt        = 1'b0;
        best_nxt       = '0;
        best_slot_nxt  = '0;
        free_vld_nxt   = 1'b0;
        res_status_nxt = zorht_pkg::ST_OK;
        rd_idx_nxt     = '0;
        case (op_r)
          zorht_pkg::OP_INSERT: begin
            if (count_r == CNT_W'(MAX_REGIONS)) begin
              res_status_nxt = zorht_pkg::ST_FULL;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_SWEEP;
            end
          end
          zorht_pkg::OP_REMOVE: begin
            if (!slot_ok) begin
              res_status_nxt = zorht_pkg::ST_UNUSED;
              state_nxt      = S_FINISH;
            end else begin
              rank_raddr = slot_idx;
              state_nxt  = S_REM_RANK;
            end
          end
          zorht_pkg::OP_SET_RECT: begin
            if (!slot_ok) begin
              res_status_nxt = zorht_pkg::ST_UNUSED;
            end else begin
              rect_we = 1'b1;
            end
            state_nxt = S_FINISH;
          end
          default: begin
            state_nxt = S_SWEEP;
          end
        endcase
      end
      S_REM_RANK: begin
        gone_nxt             = rank_rdata;
        in_use_nxt[slot_idx] = 1'b0;
        count_nxt            = count_r - CNT_W'(1);
        state_nxt            = S_SWEEP;
      end
      S_SWEEP: begin
        p_vld_nxt = 1'b1;
        p_idx_nxt = rd_idx_r;
        if (rd_idx_r == IDX_W'(MAX_REGIONS - 1)) begin
          state_nxt = S_TAIL;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      S_TAIL: begin
        state_nxt = (op_r == zorht_pkg::OP_INSERT) ? S_INS_WR : S_FINISH;
      end
      S_INS_WR: begin
        rank_we                = 1'b1;
        rank_waddr             = free_idx_r;
        rank_wdata             = '0;
        rect_we                = 1'b1;
        rect_waddr             = free_idx_r;
        in_use_nxt[free_idx_r] = 1'b1;
        count_nxt              = count_r + CNT_W'(1);
        best_slot_nxt          = free_idx_r;
        state_nxt              = S_FINISH;
      end
      S_FINISH: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = hit_r;
          out_slot_nxt   = best_slot_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_use_r  <= '0;
      count_r   <= '0;
      rd_idx_r  <= '0;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_use_r  <= in_use_nxt;
      count_r   <= count_nxt;
      rd_idx_r  <= rd_idx_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    left_r       <= left_nxt;
    top_r        <= top_nxt;
    wid_r        <= wid_nxt;
    hgt_r        <= hgt_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    p_idx_r      <= p_idx_nxt;
    gone_r       <= gone_nxt;
    free_vld_r   <= free_vld_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_r        <= hit_nxt;
    best_r       <= best_nxt;
    best_slot_r  <= best_slot_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = {out_hit_r, out_status_r};
  assign out_tdata  = {{(zorht_pkg::OUT_TDATA_W - zorht_pkg::COUNT_W
                         - zorht_pkg::SLOT_W){1'b0}},
                       zorht_pkg::COUNT_W'(out_count_r),
                       zorht_pkg::SLOT_W'(out_slot_r)};

endmodule

/* src/zorht_chk.sv */
// Port-level checker for the z-ordered rectangle hit table core, with its bind.
// Depends on zorht_pkg and the assertion macro header.
`include "z_ordered_rectangle_hit_table_core_macros.svh"

module zorht_chk #(
  parameter int MAX_REGIONS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [zorht_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [zorht_pkg::OUT_TUSER_W-1:0] out_tuser
);

  `ZORHT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `ZORHT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ZORHT_ASSERT_SAME(a_full_count, clk, rst_n, out_tvalid && (out_tuser[1:0] == zorht_pkg::ST_FULL), out_tdata[8:4] == 5'(MAX_REGIONS))
  `ZORHT_ASSERT_SAME(a_hit_ok, clk, rst_n, out_tvalid && out_tuser[2], out_tuser[1:0] == zorht_pkg::ST_OK)

endmodule

bind z_ordered_rectangle_hit_table_core zorht_chk #(.MAX_REGIONS(MAX_REGIONS)) u_zorht_chk (.*);
